FILE: hdl/tga_rle_pixel_decoder_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CHK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: hdl/trpd_pkg.sv
`timescale 1ns / 1ps
package trpd_pkg;

    localparam int CNT_W = 25;
    localparam int PB_W = 3;
    localparam int PIX_W = 32;
    localparam int REP_W = 8;
    localparam int DEF_MAX_PIXEL_BYTES = 4;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [7:0] RUN_FLAG = 8'h80;
    localparam logic [7:0] LEN_MASK = 8'h7F;

    localparam logic [PB_W-1:0] RST_PIXEL_BYTES = 3'd3;
    localparam logic [CNT_W-1:0] RST_IMAGE_PIXELS = 25'd65536;

    localparam logic CFG_PIXEL_BYTES = 1'b0;
    localparam logic CFG_IMAGE_PIXELS = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [REP_W-1:0] count;
        logic raw;
        logic more;
    } t_pix_evt;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [REP_W-1:0] repeat_res;
        logic image_end;
        logic clipped;
    } t_result;

endpackage

FILE: hdl/trpd_fifo.sv
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_macros.svh"
module trpd_fifo #(
    parameter int WIDTH = $bits(trpd_pkg::t_result),
    parameter int DEPTH = trpd_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_fifo_overflow, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_CHK(a_fifo_count, i_clk, i_rst_n, do_push && !do_pop |=> !o_empty)

endmodule

FILE: hdl/trpd_front.sv
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_macros.svh"
module trpd_front #(
    parameter int MAX_PIXEL_BYTES = trpd_pkg::DEF_MAX_PIXEL_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [trpd_pkg::PB_W-1:0]  i_pixel_bytes,
    input  logic                       i_byte_valid,
    input  logic [7:0]                 i_byte,
    output logic                       o_evt_valid,
    output trpd_pkg::t_pix_evt         o_evt
);
    localparam int BI_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RUN,
        PH_RAW
    } t_phase;

    t_phase r_phase, n_phase;
    logic [7:0] r_packet_left, n_packet_left;
    logic [BI_W-1:0] r_byte_index, n_byte_index;
    logic [trpd_pkg::PIX_W-1:0] r_gather, n_gather;
    logic [3:0] pb_eff;
    logic [3:0] bi4;
    logic [trpd_pkg::PIX_W-1:0] gather_upd;
    logic [7:0] left_dec;

    always_comb begin
        if (i_pixel_bytes == '0) begin
            pb_eff = 4'd1;
        end else if ({1'b0, i_pixel_bytes} > 4'(MAX_PIXEL_BYTES)) begin
            pb_eff = 4'(MAX_PIXEL_BYTES);
        end else begin
            pb_eff = {1'b0, i_pixel_bytes};
        end
    end

    always_comb begin
        bi4 = 4'(r_byte_index);
        gather_upd = r_gather;
        if (bi4 < 4'd4) begin
            gather_upd[{bi4[1:0], 3'b000} +: 8] = r_gather[{bi4[1:0], 3'b000} +: 8] | i_byte;
        end
        left_dec = (r_packet_left != '0) ? r_packet_left - 8'd1 : r_packet_left;
    end

    always_comb begin
        n_phase       = r_phase;
        n_packet_left = r_packet_left;
        n_byte_index  = r_byte_index;
        n_gather      = r_gather;
        o_evt_valid   = 1'b0;
        o_evt.value   = gather_upd;
        o_evt.count   = 8'd1;
        o_evt.raw     = 1'b1;
        o_evt.more    = (left_dec != '0);
        if (i_byte_valid) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_packet_left = (i_byte & trpd_pkg::LEN_MASK) + 8'd1;
                    n_phase       = ((i_byte & trpd_pkg::RUN_FLAG) != '0) ? PH_RUN : PH_RAW;
                    n_byte_index  = '0;
                    n_gather      = '0;
                end
                PH_RUN, PH_RAW: begin
                    if (bi4 + 4'd1 < pb_eff) begin
                        n_byte_index = r_byte_index + 1'b1;
                        n_gather     = gather_upd;
                    end else begin
                        n_byte_index = '0;
                        n_gather     = '0;
                        o_evt_valid  = 1'b1;
                        if (r_phase == PH_RUN) begin
                            o_evt.count   = r_packet_left;
                            o_evt.raw     = 1'b0;
                            o_evt.more    = 1'b0;
                            n_packet_left = '0;
                            n_phase       = PH_HEADER;
                        end else begin
                            n_packet_left = left_dec;
                            if (left_dec == '0) begin
                                n_phase = PH_HEADER;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_packet_left <= '0;
            r_byte_index  <= '0;
            r_gather      <= '0;
        end else begin
            r_phase       <= n_phase;
            r_packet_left <= n_packet_left;
            r_byte_index  <= n_byte_index;
            r_gather      <= n_gather;
        end
    end

    `ASSERT_CHK(a_packet_owes, i_clk, i_rst_n, r_phase != PH_HEADER |-> r_packet_left != '0)

endmodule

FILE: hdl/trpd_back.sv
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_macros.svh"
module trpd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [trpd_pkg::CNT_W-1:0]  i_image_pixels,
    input  logic                        i_evt_empty,
    input  trpd_pkg::t_pix_evt          i_evt,
    output logic                        o_evt_pop,
    input  logic                        i_res_full,
    output logic                        o_res_push,
    output trpd_pkg::t_result           o_res
);
    logic [trpd_pkg::CNT_W-1:0] r_pixels_done, n_pixels_done;
    logic r_overrun, n_overrun;
    logic [trpd_pkg::CNT_W-1:0] limit, remaining, count_ext;
    logic take_all;

    assign o_evt_pop = !i_evt_empty && !i_res_full;
    assign count_ext = trpd_pkg::CNT_W'(i_evt.count);

    always_comb begin
        limit     = (i_image_pixels == '0) ? trpd_pkg::CNT_W'(1) : i_image_pixels;
        remaining = (r_pixels_done < limit) ? limit - r_pixels_done : trpd_pkg::CNT_W'(1);
        take_all  = (count_ext >= remaining);
    end

    always_comb begin
        n_pixels_done     = r_pixels_done;
        n_overrun         = r_overrun;
        o_res_push        = 1'b0;
        o_res.pixel_value = i_evt.value;
        o_res.repeat_res  = i_evt.count;
        o_res.image_end   = 1'b0;
        o_res.clipped     = 1'b0;
        if (o_evt_pop) begin
            if (i_evt.raw && r_overrun) begin
                if (!i_evt.more) begin
                    n_overrun = 1'b0;
                end
            end else begin
                o_res_push = 1'b1;
                if (take_all) begin
                    o_res.repeat_res = remaining[trpd_pkg::REP_W-1:0];
                    o_res.image_end  = 1'b1;
                    o_res.clipped    = (count_ext > remaining) || (i_evt.raw && i_evt.more);
                    n_overrun        = i_evt.raw && i_evt.more;
                    n_pixels_done    = '0;
                end else begin
                    n_pixels_done = r_pixels_done + count_ext;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_done <= '0;
            r_overrun     <= 1'b0;
        end else begin
            r_pixels_done <= n_pixels_done;
            r_overrun     <= n_overrun;
        end
    end

    `ASSERT_CHK(a_ovr_source, i_clk, i_rst_n,
        $rose(r_overrun) |-> $past(o_evt_pop && i_evt.raw && i_evt.more))
    `ASSERT_CHK(a_end_clears, i_clk, i_rst_n,
        o_res_push && o_res.image_end |=> r_pixels_done == '0)
    `ASSERT_NEVER(a_rep_zero, i_clk, i_rst_n, o_res_push && o_res.repeat_res == '0)

endmodule

FILE: hdl/tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// TGA run-length pixel decoder.
// Input queue side: one coded byte on i_data_byte is taken at each edge with
// push high and full low. Result queue side: while empty is low the oldest
// result (pixel, repeat count, image end, clip flag) sits on the o_ ports and
// leaves at an edge with pop high. A run gives one result; each raw pixel one,
// but none past the image end. Configuration: i_cfg_index selects pixel
// bytes or image pixels, written at an edge with i_cfg_valid high;
// o_cfg_ready is always high. Write only idle. Throughput: one byte per
// cycle while full is low, set by the byte parser; the pixel counter retires
// one event per cycle while the result queue has room, a two-entry queue
// between them. When pop stays low the two-entry result queue fills, then
// the event queue, and full rises; nothing is lost. Reset (i_rst_n low at an
// edge) empties both queues, waits for a packet header and restores pixel
// bytes 3 and image pixels 65536. No clearing pass follows reset.
module tga_rle_pixel_decoder #(
    parameter int MAX_PIXEL_BYTES = trpd_pkg::DEF_MAX_PIXEL_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_data_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [trpd_pkg::PIX_W-1:0]    o_pixel_value,
    output logic [trpd_pkg::REP_W-1:0]    o_repeat_res,
    output logic                          o_image_end,
    output logic                          o_clipped,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [trpd_pkg::CNT_W-1:0]    i_cfg_data
);
    localparam int EVT_W = $bits(trpd_pkg::t_pix_evt);
    localparam int RES_W = $bits(trpd_pkg::t_result);

    logic [trpd_pkg::PB_W-1:0] r_pixel_bytes;
    logic [trpd_pkg::CNT_W-1:0] r_image_pixels;
    logic byte_take;
    logic evt_valid, evt_pop, evt_empty;
    trpd_pkg::t_pix_evt evt_in, evt_out;
    logic [EVT_W-1:0] evt_q;
    logic res_full, res_push;
    trpd_pkg::t_result res_in, res_out;
    logic [RES_W-1:0] res_q;

    assign o_cfg_ready = 1'b1;
    assign byte_take   = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes  <= trpd_pkg::RST_PIXEL_BYTES;
            r_image_pixels <= trpd_pkg::RST_IMAGE_PIXELS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                trpd_pkg::CFG_PIXEL_BYTES:  r_pixel_bytes  <= i_cfg_data[trpd_pkg::PB_W-1:0];
                trpd_pkg::CFG_IMAGE_PIXELS: r_image_pixels <= i_cfg_data;
                default: ;
            endcase
        end
    end

    trpd_front #(
        .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pixel_bytes(r_pixel_bytes),
        .i_byte_valid (byte_take),
        .i_byte       (i_data_byte),
        .o_evt_valid  (evt_valid),
        .o_evt        (evt_in)
    );

    trpd_fifo #(
        .WIDTH(EVT_W),
        .DEPTH(trpd_pkg::DEF_QUEUE_DEPTH)
    ) u_evt_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (evt_valid),
        .i_data (evt_in),
        .o_full (full),
        .i_pop  (evt_pop),
        .o_data (evt_q),
        .o_empty(evt_empty)
    );

    assign evt_out = evt_q;

    trpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_image_pixels(r_image_pixels),
        .i_evt_empty   (evt_empty),
        .i_evt         (evt_out),
        .o_evt_pop     (evt_pop),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    trpd_fifo #(
        .WIDTH(RES_W),
        .DEPTH(trpd_pkg::DEF_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_q),
        .o_empty(empty)
    );

    assign res_out       = res_q;
    assign o_pixel_value = res_out.pixel_value;
    assign o_repeat_res  = res_out.repeat_res;
    assign o_image_end   = res_out.image_end;
    assign o_clipped     = res_out.clipped;

endmodule
